FILE: hdl/acaf_pkg.sv
package acaf_pkg;

  localparam int NumChannels = 7;
  localparam int FrameBytes  = 12;
  localparam int SumWidth    = 16;

  localparam logic [7:0] SyncByte0  = 8'h55;
  localparam logic [7:0] SyncByte1  = 8'hAA;
  localparam logic [7:0] LengthByte = 8'd8;

  localparam logic [2:0] LastChannel = 3'(NumChannels - 1);
  localparam logic [3:0] LastByte    = 4'(FrameBytes - 1);

  typedef logic [NumChannels-1:0][SumWidth-1:0] sum_vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkSend
  } back_state_e;

endpackage

FILE: hdl/adc_channel_average_framer_top.sv
// Channel   Direction  Handshake     Fields
// sample    in         push_i/full_o sample_i[7:0]
// frame     out        pop_i/empty_o frame_byte_o[7:0], frame_last_o
//
// One sample word is taken every cycle; full_o rises only on the block-ending
// sample while both queued sum snapshots are still waiting for the back end.
// Each frame runs through a start step in BkIdle, the averages in BkDiv around one shared
// multiplier and then the output words in BkSend, twelve in all, as pop_i allows.
// Reset clears all counters, sums and the frame counter at once.
module adc_channel_average_framer_top #(
  parameter int ScanLoops = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] sample_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  acaf_pkg::q_stat_t  q_stat;
  acaf_pkg::sum_vec_t q_wdata;
  acaf_pkg::sum_vec_t q_rdata;
  logic               q_push;
  logic               q_pop;

  acaf_front #(
    .ScanLoops(ScanLoops)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .sample_i(sample_i),
    .full_o  (full_o),
    .q_stat_i(q_stat),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  acaf_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_wdata),
    .pop_i (q_pop),
    .data_o(q_rdata),
    .stat_o(q_stat)
  );

  acaf_back #(
    .ScanLoops(ScanLoops)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_stat.full))
    else $error("Sum snapshot written into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_stat.empty))
    else $error("Sum snapshot taken from an empty queue.");

  a_full_only_when_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> q_stat.full)
    else $error("Input stalled while the queue has room.");

endmodule

FILE: hdl/acaf_front.sv
module acaf_front #(
  parameter int ScanLoops = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        sample_i,
  output logic              full_o,
  input  acaf_pkg::q_stat_t q_stat_i,
  output logic              q_push_o,
  output acaf_pkg::sum_vec_t q_data_o
);

  localparam int ScanW = (ScanLoops > 1) ? $clog2(ScanLoops) : 1;
  localparam logic [ScanW-1:0] LastScan = ScanW'(ScanLoops - 1);

  logic [acaf_pkg::SumWidth-1:0] sums_q [acaf_pkg::NumChannels];
  logic [2:0]                    pos_q, pos_d;
  logic [ScanW-1:0]              scan_q, scan_d;
  logic                          block_end;
  logic                          accept;
  logic [acaf_pkg::SumWidth-1:0] new_sum;

  assign block_end = (pos_q == acaf_pkg::LastChannel) && (scan_q == LastScan);
  assign full_o    = block_end && q_stat_i.full;
  assign accept    = push_i && !full_o;
  assign new_sum   = sums_q[pos_q] + acaf_pkg::SumWidth'(sample_i);
  assign q_push_o  = accept && block_end;

  always_comb begin
    for (int c = 0; c < acaf_pkg::NumChannels; c++) begin
      q_data_o[c] = sums_q[c];
    end
    q_data_o[acaf_pkg::NumChannels-1] = new_sum;
  end

  always_comb begin
    pos_d  = pos_q;
    scan_d = scan_q;
    if (accept) begin
      if (pos_q == acaf_pkg::LastChannel) begin
        pos_d  = '0;
        scan_d = (scan_q == LastScan) ? '0 : scan_q + 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      scan_q <= '0;
      for (int c = 0; c < acaf_pkg::NumChannels; c++) begin
        sums_q[c] <= '0;
      end
    end else begin
      pos_q  <= pos_d;
      scan_q <= scan_d;
      if (accept) begin
        if (block_end) begin
          for (int c = 0; c < acaf_pkg::NumChannels; c++) begin
            sums_q[c] <= '0;
          end
        end else begin
          sums_q[pos_q] <= new_sum;
        end
      end
    end
  end

endmodule

FILE: hdl/acaf_fifo.sv
module acaf_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  acaf_pkg::sum_vec_t data_i,
  input  logic               pop_i,
  output acaf_pkg::sum_vec_t data_o,
  output acaf_pkg::q_stat_t  stat_o
);

  acaf_pkg::sum_vec_t mem_q [2];
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         count_q;
  logic               do_push;
  logic               do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: hdl/acaf_back.sv
module acaf_back #(
  parameter int ScanLoops = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acaf_pkg::q_stat_t  q_stat_i,
  input  acaf_pkg::sum_vec_t q_data_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         frame_byte_o,
  output logic               frame_last_o
);

  // Division by the scan count is a multiplication by a rounded-up reciprocal.
  localparam int Shift = acaf_pkg::SumWidth + $clog2(ScanLoops);
  localparam logic [16:0] MultK = 17'(((1 << Shift) + ScanLoops - 1) / ScanLoops);

  acaf_pkg::back_state_e state_q, state_d;

  logic [2:0]  cnt_q;
  logic [3:0]  idx_q;
  logic [32:0] prod_q;
  logic [7:0]  avg_q [acaf_pkg::NumChannels];
  logic [7:0]  csum_q;
  logic [7:0]  frame_cnt_q;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [7:0]  quot;
  logic [7:0]  next_byte;
  logic        load_out;
  logic        start_div;
  logic        div_done;

  assign quot         = prod_q[Shift +: 8];
  assign empty_o      = !out_valid_q;
  assign frame_byte_o = byte_q;
  assign frame_last_o = last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acaf_pkg::BkIdle: begin
        if (!q_stat_i.empty) begin
          state_d = acaf_pkg::BkDiv;
        end
      end
      acaf_pkg::BkDiv: begin
        if (cnt_q == 3'd7) begin
          state_d = acaf_pkg::BkSend;
        end
      end
      acaf_pkg::BkSend: begin
        if (load_out && idx_q == acaf_pkg::LastByte) begin
          state_d = acaf_pkg::BkIdle;
        end
      end
      default: state_d = acaf_pkg::BkIdle;
    endcase
  end

  always_comb begin
    start_div = 1'b0;
    div_done  = 1'b0;
    load_out  = 1'b0;
    q_pop_o   = 1'b0;
    unique case (state_q)
      acaf_pkg::BkIdle: start_div = !q_stat_i.empty;
      acaf_pkg::BkDiv: begin
        div_done = (cnt_q == 3'd7);
        q_pop_o  = div_done;
      end
      acaf_pkg::BkSend: load_out = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  always_comb begin
    unique case (idx_q)
      4'd0:    next_byte = acaf_pkg::SyncByte0;
      4'd1:    next_byte = acaf_pkg::SyncByte1;
      4'd2:    next_byte = acaf_pkg::LengthByte;
      4'd3:    next_byte = avg_q[0];
      4'd4:    next_byte = avg_q[1];
      4'd5:    next_byte = avg_q[2];
      4'd6:    next_byte = avg_q[3];
      4'd7:    next_byte = avg_q[4];
      4'd8:    next_byte = avg_q[5];
      4'd9:    next_byte = avg_q[6];
      4'd10:   next_byte = frame_cnt_q;
      default: next_byte = csum_q + frame_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acaf_pkg::BkDiv) begin
      if (cnt_q != 3'd7) begin
        prod_q <= 33'(q_data_i[cnt_q]) * 33'(MultK);
      end
      if (cnt_q != 3'd0) begin
        avg_q[cnt_q - 3'd1] <= quot;
      end
    end
    if (start_div) begin
      csum_q <= acaf_pkg::LengthByte;
    end else if (state_q == acaf_pkg::BkDiv && cnt_q != 3'd0) begin
      csum_q <= csum_q + quot;
    end
    if (load_out) begin
      byte_q <= next_byte;
      last_q <= (idx_q == acaf_pkg::LastByte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acaf_pkg::BkIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      frame_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_div) begin
        cnt_q <= '0;
      end else if (state_q == acaf_pkg::BkDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (div_done) begin
        frame_cnt_q <= frame_cnt_q + 1'b1;
        idx_q       <= '0;
      end else if (load_out) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
